// ----- design/tecl_pkg.sv -----
// Shared types, codes and constants of the TCP endpoint class lookup unit.
`default_nettype none
package tecl_pkg;

    localparam int KEY_BITS   = 48;
    localparam int ENTRY_BITS = KEY_BITS + 1;

    localparam logic [1:0] FUNC_CLASSIFY = 2'd0;
    localparam logic [1:0] FUNC_INSERT   = 2'd1;
    localparam logic [1:0] FUNC_REMOVE   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    localparam logic [1:0] MATCH_NONE = 2'd0;
    localparam logic [1:0] MATCH_DST  = 2'd1;
    localparam logic [1:0] MATCH_SRC  = 2'd2;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [31:0] HASH_MULT = 32'h9E3779B1;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [31:0] new_class;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  matched_by;
        logic [31:0] flow_class;
        logic [1:0]  op_status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_READ,
        S_CHECK,
        S_CLASS,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       sel_src;
        logic       hash1;
        logic       hash2;
        logic       rd_row;
        logic       rd_cls;
        logic       wr_ins;
        logic       wr_rem;
        logic       clr_wr;
        logic       out_load;
        logic [1:0] matched_by;
        logic [1:0] op_status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       eligible;
        logic       hit;
        logic       free;
        logic       clr_last;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- design/tcp_endpoint_class_lookup_unit.sv -----
// Top level of the TCP endpoint class lookup unit.
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | t_in_item
//  out     | output    | o_out_valid / i_out_stall | t_out_item
//
// A classify item looks up the destination key and, on a miss, the source key;
// insert and remove make one lookup, non-TCP and unused items none.
// Each lookup pass is two hash multiply steps, one bucket row read and a
// compare; a hit adds one class memory read. After reset a clearing pass
// writes one bucket row a cycle, all TABLE_ENTRIES / BUCKET_WAYS rows, with no
// item accepted. One result item waits in the output register under stall.
`default_nettype none
module tcp_endpoint_class_lookup_unit #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int BUCKET_WAYS   = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire tecl_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tecl_pkg::t_out_item     o_out_item
);
    import tecl_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tecl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tecl_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BUCKET_WAYS   (BUCKET_WAYS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );
endmodule
`default_nettype wire

// ----- design/tecl_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tecl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- design/tecl_ctrl.sv -----
// Controller state machine of the TCP endpoint class lookup unit.
`default_nettype none
module tecl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tecl_pkg::t_sts i_sts,
    output tecl_pkg::t_cmd     o_cmd
);
    import tecl_pkg::*;

    t_state     r_state, n_state;
    logic       r_src, n_src;
    logic [1:0] r_match, n_match;
    logic [1:0] r_status, n_status;

    // State and per-item control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_src    <= 1'b0;
            r_match  <= MATCH_NONE;
            r_status <= STATUS_DONE;
        end else begin
            r_state  <= n_state;
            r_src    <= n_src;
            r_match  <= n_match;
            r_status <= n_status;
        end
    end

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_src    = r_src;
        n_match  = r_match;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.matched_by = r_match;
        o_cmd.op_status  = r_status;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_src      = 1'b0;
                    n_match    = MATCH_NONE;
                    n_status   = STATUS_DONE;
                    n_state    = S_HASH1;
                end
            end
            S_HASH1: begin
                o_cmd.hash1 = 1'b1;
                if ((i_sts.func != FUNC_CLASSIFY && i_sts.func != FUNC_INSERT &&
                     i_sts.func != FUNC_REMOVE) ||
                    (i_sts.func == FUNC_CLASSIFY && !i_sts.eligible)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_HASH2;
                end
            end
            S_HASH2: begin
                o_cmd.hash2 = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_DONE;
                case (i_sts.func)
                    FUNC_CLASSIFY: begin
                        if (i_sts.hit) begin
                            o_cmd.rd_cls = 1'b1;
                            n_match = r_src ? MATCH_SRC : MATCH_DST;
                            n_state = S_CLASS;
                        end else if (!r_src) begin
                            o_cmd.sel_src = 1'b1;
                            n_src   = 1'b1;
                            n_state = S_HASH1;
                        end
                    end
                    FUNC_INSERT: begin
                        if (i_sts.hit || i_sts.free) begin
                            o_cmd.wr_ins = 1'b1;
                        end else begin
                            n_status = STATUS_FULL;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (i_sts.hit) begin
                            o_cmd.wr_rem = 1'b1;
                        end else begin
                            n_status = STATUS_ABSENT;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CLASS: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- design/tecl_datapath.sv -----
// Datapath of the TCP endpoint class lookup unit: key, hash, table and result.
`default_nettype none
module tecl_datapath #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int BUCKET_WAYS   = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tecl_pkg::t_in_item i_in_item,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output tecl_pkg::t_out_item     o_out_item,
    input  wire tecl_pkg::t_cmd     i_cmd,
    output tecl_pkg::t_sts          o_sts
);
    import tecl_pkg::*;

    localparam int NUM_BUCKETS = TABLE_ENTRIES / BUCKET_WAYS;
    localparam int ROW_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CLS_DEPTH = NUM_BUCKETS * BUCKET_WAYS;
    localparam int CLS_W    = (CLS_DEPTH > 1) ? $clog2(CLS_DEPTH) : 1;
    localparam int WAY_W    = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
    localparam int ROW_BITS = BUCKET_WAYS * ENTRY_BITS;
    localparam logic [16:0] NB_C = 17'(NUM_BUCKETS);

    t_in_item              r_item;
    logic [KEY_BITS-1:0]   r_key;
    logic [31:0]           r_hash;
    logic [ROW_W-1:0]      r_bucket;
    logic [ROW_W-1:0]      r_clr;
    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic [ROW_BITS-1:0]   row_rdata;
    logic [ROW_BITS-1:0]   row_wdata;
    logic [31:0]           cls_rdata;
    logic [31:0]           hash_fold;
    logic [31:0]           hash_mul;
    logic [48:0]           bucket_mul;
    logic                  hit;
    logic                  free;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      sel_way;
    logic [CLS_W-1:0]      slot;
    logic                  row_we;
    logic [ROW_W-1:0]      row_waddr;

    // Hold item and lookup key
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
            r_key  <= {i_in_item.dst_ip, i_in_item.dst_port};
        end else if (i_cmd.sel_src) begin
            r_key  <= {r_item.src_ip, r_item.src_port};
        end
    end

    // Hash in two registered multiply steps
    assign hash_fold  = r_key[47:16] ^ {r_key[15:0], r_key[47:32]};
    assign hash_mul   = hash_fold * HASH_MULT;
    assign bucket_mul = 49'(r_hash) * 49'(NB_C);

    always_ff @(posedge i_clk) begin
        if (i_cmd.hash1) begin
            r_hash <= hash_mul;
        end
        if (i_cmd.hash2) begin
            r_bucket <= bucket_mul[32 +: ROW_W];
        end
    end

    // Advance clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // Find first hit and first free way of the bucket row
    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
            if (row_rdata[w*ENTRY_BITS + KEY_BITS] &&
                row_rdata[w*ENTRY_BITS +: KEY_BITS] == r_key) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!row_rdata[w*ENTRY_BITS + KEY_BITS]) begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    assign sel_way = hit ? hit_way : free_way;
    assign slot    = CLS_W'(r_bucket) * CLS_W'(BUCKET_WAYS) + CLS_W'(sel_way);

    // Build the modified row for insert, remove or the clearing pass
    always_comb begin
        row_wdata = row_rdata;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (WAY_W'(w) == sel_way) begin
                if (i_cmd.wr_ins) begin
                    row_wdata[w*ENTRY_BITS +: ENTRY_BITS] = {1'b1, r_key};
                end else if (i_cmd.wr_rem) begin
                    row_wdata[w*ENTRY_BITS +: ENTRY_BITS] = '0;
                end
            end
        end
        if (i_cmd.clr_wr) begin
            row_wdata = '0;
        end
    end

    assign row_we    = i_cmd.clr_wr | i_cmd.wr_ins | i_cmd.wr_rem;
    assign row_waddr = i_cmd.clr_wr ? r_clr : r_bucket;

    tecl_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NUM_BUCKETS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (row_we),
        .i_wr_addr (row_waddr),
        .i_wr_data (row_wdata),
        .i_rd_en   (i_cmd.rd_row),
        .i_rd_addr (r_bucket),
        .o_rd_data (row_rdata)
    );

    tecl_ram #(
        .WIDTH (32),
        .DEPTH (CLS_DEPTH)
    ) u_cls_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_ins),
        .i_wr_addr (slot),
        .i_wr_data (r_item.new_class),
        .i_rd_en   (i_cmd.rd_cls),
        .i_rd_addr (slot),
        .o_rd_data (cls_rdata)
    );

    // Hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_item.matched_by <= i_cmd.matched_by;
            r_out_item.flow_class <= (i_cmd.matched_by != MATCH_NONE) ? cls_rdata : 32'd0;
            r_out_item.op_status  <= i_cmd.op_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign o_sts.func     = r_item.func;
    assign o_sts.eligible = (r_item.ether_type == ETH_IPV4) &&
                            (r_item.ip_protocol == PROTO_TCP);
    assign o_sts.hit      = hit;
    assign o_sts.free     = free;
    assign o_sts.clr_last = (r_clr == ROW_W'(NUM_BUCKETS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
endmodule
`default_nettype wire

// ----- dv/tb_tcp_endpoint_class_lookup_unit.sv -----
// Testbench of the TCP endpoint class lookup unit: directed table, table fill and random items.
`default_nettype none
module tb_tcp_endpoint_class_lookup_unit;
    import tecl_pkg::*;

    localparam int TABLE_SLOTS = 4096;
    localparam int WAYS        = 4;
    localparam int FILL_KEYS   = 250;
    localparam int PROBE_ITEMS = 30;
    localparam int RAND_ITEMS  = 600;
    localparam int QUIET_ITEMS = 150;
    localparam int HOLD_CYCLES = 200;
    localparam int POOL_SIZE   = 16;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item want;
    } t_pending;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    tcp_endpoint_class_lookup_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Shadow of the endpoint table: key {ip, port} to class id
    logic [31:0] shadow_class [logic [47:0]];
    t_pending    pending_q [$];
    t_pending    directed_rows [$];
    int          mismatch_count = 0;
    int          fail_count     = 0;
    bit          quiet          = 0;
    bit          hold_req       = 0;
    bit          hold_done      = 0;
    int          hold_count     = 0;
    int          stall_left     = 0;
    logic [31:0] pool_ip   [POOL_SIZE];
    logic [15:0] pool_port [POOL_SIZE];

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Run limit
    initial begin
        #2500000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_in_item make_item(logic [1:0] func, logic [15:0] eth,
                                           logic [7:0] proto, logic [31:0] dip,
                                           logic [15:0] dport, logic [31:0] sip,
                                           logic [15:0] sport, logic [31:0] cls);
        t_in_item it;
        it.func        = func;
        it.ether_type  = eth;
        it.ip_protocol = proto;
        it.dst_ip      = dip;
        it.dst_port    = dport;
        it.src_ip      = sip;
        it.src_port    = sport;
        it.new_class   = cls;
        return it;
    endfunction

    function automatic t_out_item make_out(logic [1:0] m, logic [31:0] c, logic [1:0] s);
        t_out_item o;
        o.matched_by = m;
        o.flow_class = c;
        o.op_status  = s;
        return o;
    endfunction

    // Work out the result of one item and advance the shadow table. Placement is the
    // block's own, so a new key may be refused once enough keys are live; take the
    // block's answer there and follow it.
    task automatic predict_result(input t_in_item it, input t_out_item got,
                                  output t_out_item want);
        logic [47:0] dkey;
        logic [47:0] skey;
        dkey = {it.dst_ip, it.dst_port};
        skey = {it.src_ip, it.src_port};
        want = make_out(MATCH_NONE, 32'd0, STATUS_DONE);
        case (it.func)
            FUNC_CLASSIFY: begin
                if (it.ether_type == ETH_IPV4 && it.ip_protocol == PROTO_TCP) begin
                    if (shadow_class.exists(dkey)) begin
                        want = make_out(MATCH_DST, shadow_class[dkey], STATUS_DONE);
                    end else if (shadow_class.exists(skey)) begin
                        want = make_out(MATCH_SRC, shadow_class[skey], STATUS_DONE);
                    end
                end
            end
            FUNC_INSERT: begin
                if (shadow_class.exists(dkey) || shadow_class.num() < WAYS) begin
                    shadow_class[dkey] = it.new_class;
                end else if (shadow_class.num() >= TABLE_SLOTS) begin
                    want.op_status = STATUS_FULL;
                end else if (got.op_status == STATUS_FULL) begin
                    want.op_status = STATUS_FULL;
                end else begin
                    shadow_class[dkey] = it.new_class;
                end
            end
            FUNC_REMOVE: begin
                if (shadow_class.exists(dkey)) shadow_class.delete(dkey);
                else want.op_status = STATUS_ABSENT;
            end
            default: ;
        endcase
    endtask

    // Check each result item against the oldest expectation
    always @(posedge i_clk) begin
        t_pending  p;
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item: m=%0d c=%h s=%0d",
                             o_out_item.matched_by, o_out_item.flow_class,
                             o_out_item.op_status);
            end else begin
                p = pending_q.pop_front();
                predict_result(p.item, o_out_item, want);
                if (p.fixed) want = p.want;
                if (o_out_item.matched_by !== want.matched_by ||
                    o_out_item.flow_class !== want.flow_class ||
                    o_out_item.op_status !== want.op_status) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch func=%0d: exp m=%0d c=%h s=%0d got m=%0d c=%h s=%0d",
                                 p.item.func, want.matched_by, want.flow_class,
                                 want.op_status, o_out_item.matched_by,
                                 o_out_item.flow_class, o_out_item.op_status);
                end
            end
        end
    end

    // Drive the output stall: one long hold-off on request, else random bursts, none while quiet
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_out_stall = 1'b1;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
        end else if (quiet) begin
            i_out_stall = 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall = 1'b1;
            stall_left  = $urandom_range(1, 10) - 1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Offer one item, hold it until accepted and log the expectation
    task automatic send_item(input t_in_item it, input bit fixed, input t_out_item want);
        t_pending p;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (o_in_stall);
        p.item  = it;
        p.fixed = fixed;
        p.want  = want;
        pending_q.push_back(p);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic add_row(input t_in_item it, input bit fixed, input t_out_item want);
        t_pending p;
        p.item  = it;
        p.fixed = fixed;
        p.want  = want;
        directed_rows.push_back(p);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        int       a;
        int       b;
        it   = make_item(2'($urandom), 16'($urandom), 8'($urandom), $urandom,
                         16'($urandom), $urandom, 16'($urandom), $urandom);
        pick = $urandom_range(0, 99);
        a    = $urandom_range(0, POOL_SIZE - 1);
        b    = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 7) != 0) begin
            it.dst_ip   = pool_ip[a];
            it.dst_port = pool_port[a];
        end
        if ($urandom_range(0, 3) != 0) begin
            it.src_ip   = pool_ip[b];
            it.src_port = pool_port[b];
        end
        if (pick < 50) begin
            it.func = FUNC_CLASSIFY;
            if ($urandom_range(0, 9) != 0) it.ether_type = ETH_IPV4;
            if ($urandom_range(0, 9) != 0) it.ip_protocol = PROTO_TCP;
        end else if (pick < 77) begin
            it.func = FUNC_INSERT;
        end else if (pick < 96) begin
            it.func = FUNC_REMOVE;
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    initial begin
        t_out_item none;
        t_pending  row;
        t_in_item  it;
        int        j;
        none        = make_out(MATCH_NONE, 32'd0, STATUS_DONE);
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: empty table, extremes, overwrite, ignored items, error codes
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, 32'h0a000001, 16'd80,
                          32'h0a000002, 16'd1234, 32'd0), 1, none);
        add_row(make_item(FUNC_REMOVE, 16'h0, 8'h0, 32'hffffffff, 16'hffff,
                          32'h0, 16'h0, 32'h0), 1,
                make_out(MATCH_NONE, 32'd0, STATUS_ABSENT));
        add_row(make_item(FUNC_UNUSED, 16'hffff, 8'hff, 32'hffffffff, 16'hffff,
                          32'hffffffff, 16'hffff, 32'hffffffff), 1, none);
        add_row(make_item(FUNC_INSERT, 16'hffff, 8'hff, 32'hffffffff, 16'hffff,
                          32'hffffffff, 16'hffff, 32'hffffffff), 1, none);
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, 32'hffffffff, 16'hffff,
                          32'h0, 16'h0, 32'h0), 1,
                make_out(MATCH_DST, 32'hffffffff, STATUS_DONE));
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, 32'h01020304, 16'd443,
                          32'hffffffff, 16'hffff, 32'h0), 1,
                make_out(MATCH_SRC, 32'hffffffff, STATUS_DONE));
        add_row(make_item(FUNC_INSERT, 16'h0, 8'h0, 32'hffffffff, 16'hffff,
                          32'h0, 16'h0, 32'h0), 1, none);
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, 32'hffffffff, 16'hffff,
                          32'h0, 16'h0, 32'h0), 1, make_out(MATCH_DST, 32'd0, STATUS_DONE));
        add_row(make_item(FUNC_CLASSIFY, 16'hffff, PROTO_TCP, 32'hffffffff, 16'hffff,
                          32'h0, 16'h0, 32'h0), 1, none);
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, 8'd17, 32'hffffffff, 16'hffff,
                          32'h0, 16'h0, 32'h0), 1, none);
        add_row(make_item(FUNC_INSERT, 16'h1234, 8'h55, 32'h0, 16'h0,
                          32'h89abcdef, 16'h4321, 32'h12345678), 1, none);
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, 32'h0, 16'h0,
                          32'hffffffff, 16'hffff, 32'h0), 1,
                make_out(MATCH_DST, 32'h12345678, STATUS_DONE));
        add_row(make_item(FUNC_REMOVE, 16'h0800, 8'h6, 32'hffffffff, 16'hffff,
                          32'h0, 16'h0, 32'hdeadbeef), 1, none);
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, 32'h01020304, 16'd443,
                          32'hffffffff, 16'hffff, 32'h0), 1, none);
        add_row(make_item(FUNC_REMOVE, 16'h0, 8'h0, 32'hffffffff, 16'hffff,
                          32'h0, 16'h0, 32'h0), 1,
                make_out(MATCH_NONE, 32'd0, STATUS_ABSENT));
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, 32'h01020304, 16'd443,
                          32'h0, 16'h0, 32'h0), 1,
                make_out(MATCH_SRC, 32'h12345678, STATUS_DONE));
        add_row(make_item(FUNC_INSERT, 16'($urandom), 8'($urandom), 32'h7f000001,
                          16'd8080, $urandom, 16'($urandom), $urandom), 0, none);
        add_row(make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, 32'h0, 16'h0,
                          32'h7f000001, 16'd8080, $urandom), 0, none);
        add_row(make_item(FUNC_REMOVE, 16'h0, 8'h0, 32'h0, 16'h0,
                          32'h0, 16'h0, 32'h0), 1, none);
        add_row(make_item(FUNC_REMOVE, 16'h0, 8'h0, 32'h7f000001, 16'd8080,
                          32'h0, 16'h0, 32'h0), 1, none);
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.item, row.fixed, row.want);
        end

        // Fill part of the table, probe the stored keys, then empty the table
        for (int k = 0; k < FILL_KEYS; k++) begin
            it = make_item(FUNC_INSERT, 16'($urandom), 8'($urandom), k * 32'h9e3779b9,
                           k[15:0], $urandom, 16'($urandom), $urandom);
            send_item(it, 0, none);
        end
        for (int k = 0; k < PROBE_ITEMS; k++) begin
            j  = $urandom_range(0, FILL_KEYS - 1);
            it = make_item(FUNC_CLASSIFY, ETH_IPV4, PROTO_TCP, j * 32'h9e3779b9,
                           j[15:0], $urandom, 16'($urandom), $urandom);
            send_item(it, 0, none);
        end
        for (int k = 0; k < FILL_KEYS; k++) begin
            it = make_item(FUNC_REMOVE, 16'($urandom), 8'($urandom), k * 32'h9e3779b9,
                           k[15:0], $urandom, 16'($urandom), $urandom);
            send_item(it, 0, none);
        end

        // Random items over a small endpoint pool so that hits are common
        for (int k = 0; k < POOL_SIZE; k++) begin
            pool_ip[k]   = $urandom;
            pool_port[k] = 16'($urandom);
        end
        pool_ip[0]   = 32'h0;
        pool_port[0] = 16'h0;
        pool_ip[1]   = 32'hffffffff;
        pool_port[1] = 16'hffff;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS / 3) hold_req = 1'b1;
            if (k == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_item(random_item(), 0, none);
        end

        // Drain
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
